// ===== hdl/shl_pkg.sv =====
// Shared types and codes for the segment height lookup.
`default_nettype none
package shl_pkg;
    localparam int CoordW  = 16;
    localparam int HeightW = 24;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_VERTICAL = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic signed [CoordW-1:0] lx;
        logic signed [CoordW-1:0] ly;
        logic signed [CoordW-1:0] rx;
        logic signed [CoordW-1:0] ry;
    } t_seg;
endpackage
`default_nettype wire

// ===== hdl/shl_cell.sv =====
// One storage cell of the segment chain: holds a segment and shifts it on.
`default_nettype none
module shl_cell (
    input  wire logic          i_clk,
    input  wire logic          i_shift,
    input  wire shl_pkg::t_seg i_seg,
    output shl_pkg::t_seg      o_seg
);
    import shl_pkg::*;
    t_seg r_seg;

    // Hold unless the chain rotates or loads.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_seg <= i_seg;
        end
    end
    assign o_seg = r_seg;
endmodule
`default_nettype wire

// ===== hdl/shl_div.sv =====
// Restoring divider: 41-bit unsigned numerator by 17-bit divisor, one bit a cycle.
`default_nettype none
module shl_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [40:0] i_num,
    input  wire logic [16:0] i_den,
    output logic             o_done,
    output logic [40:0]      o_quo
);
    logic [40:0] r_quo;
    logic [17:0] r_rem;
    logic [16:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic [17:0] n_trial;
    logic [17:0] n_sub;

    always_comb begin
        n_trial = {r_rem[16:0], r_quo[40]};
        n_sub   = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_start && r_run && (r_cnt == 6'd40);
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 6'd0;
                r_quo <= i_num;
                r_rem <= 18'd0;
                r_den <= i_den;
            end else if (r_run) begin
                if (!n_sub[17]) begin
                    r_rem <= n_sub;
                    r_quo <= {r_quo[39:0], 1'b1};
                end else begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[39:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd40) begin
                    r_run <= 1'b0;
                end
            end
        end
    end
    assign o_quo = r_quo;
endmodule
`default_nettype wire

// ===== hdl/segment_height_lookup_top.sv =====
// Top level of the segment height lookup: cell chain, scan control and divider.
// Add: add step, done state, strobe; clear, full add and spare code go to done.
// Query: scan of every cell, prep, divider load, divide, done, strobe (no match or
// vertical: scan, prep, done). One item at a time; the next transfer is accepted
// while the strobe is high, and the receiver cannot stall. Synchronous reset
// empties the table and idles control; cells, status, found and height are kept.
`default_nettype none
module segment_height_lookup_top #(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_action,
    input  wire logic signed [15:0]  i_left_x,
    input  wire logic signed [15:0]  i_left_y,
    input  wire logic signed [15:0]  i_right_x,
    input  wire logic signed [15:0]  i_right_y,
    input  wire logic signed [15:0]  i_query_x,
    output logic                     o_strobe,
    output logic                     o_found,
    output logic signed [23:0]       o_height,
    output logic [1:0]               o_status
);
    import shl_pkg::*;

    localparam int CntW = $clog2(MAX_SEGMENTS + 1);
    localparam int IdxW = $clog2(MAX_SEGMENTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        r_state;
    logic [CntW-1:0]   r_count;
    logic [IdxW-1:0]   r_pos;
    logic              r_hit;
    t_seg              r_pick;
    t_seg              r_new;
    logic signed [15:0] r_qx;
    logic              r_neg;
    logic              r_div_go;
    logic [40:0]       r_num;
    logic [16:0]       r_den;

    // The chain: cell 0 is fed either the new segment (add) or the tail (rotate).
    t_seg w_seg [MAX_SEGMENTS];
    logic w_shift;
    t_seg w_head;

    assign w_head  = (r_state == S_ADD) ? r_new : w_seg[MAX_SEGMENTS-1];
    assign w_shift = (r_state == S_ADD) || (r_state == S_SCAN);

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
            shl_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_seg  ((g == 0) ? w_head : w_seg[(g == 0) ? 0 : g-1]),
                .o_seg  (w_seg[g])
            );
        end
    endgenerate

    // Newest segment lives at cell 0, segment k back lives at cell k. During a
    // full rotation the tail shows cells in order oldest first at positions
    // counting down, so the last covering one seen is the newest.
    t_seg w_tail;
    logic [CntW-1:0] w_age;
    logic w_valid, w_cover;
    assign w_tail  = w_seg[MAX_SEGMENTS-1];
    // Tail at step p holds the segment that was at cell MAX_SEGMENTS-1-p.
    assign w_age   = CntW'(MAX_SEGMENTS - 1) - CntW'(r_pos);
    assign w_valid = w_age < r_count;
    assign w_cover = ($signed(w_tail.lx) <= r_qx) && ($signed(w_tail.rx) >= r_qx);

    logic        w_div_done;
    logic [40:0] w_quo;
    shl_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_go),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_done (w_div_done),
        .o_quo  (w_quo)
    );

    // Slope terms of the chosen segment.
    logic signed [16:0] w_w, w_d, w_dy;
    logic signed [33:0] w_prod;
    logic [33:0]        w_mag;
    assign w_w    = 17'(r_pick.rx) - 17'(r_pick.lx);
    assign w_d    = 17'(r_qx) - 17'(r_pick.lx);
    assign w_dy   = 17'(r_pick.ry) - 17'(r_pick.ly);
    assign w_prod = w_dy * w_d;
    assign w_mag  = w_prod[33] ? 34'(-w_prod) : 34'(w_prod);

    logic signed [23:0] w_q24;
    assign w_q24 = r_neg ? -$signed(w_quo[23:0]) : $signed(w_quo[23:0]);

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_div_go <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            // Strobe the result as the done state hands back to idle.
            o_strobe <= (r_state == S_DONE);
            // Kick the divider when the prep step finds a usable segment.
            r_div_go <= (r_state == S_PREP) && r_hit && (w_w != 17'sd0);
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        o_found  <= 1'b0;
                        o_height <= '0;
                        o_status <= ((i_action == ACT_ADD) &&
                                     (r_count >= CntW'(MAX_SEGMENTS))) ? ST_FULL : ST_OK;
                        r_new    <= '{i_left_x, i_left_y, i_right_x, i_right_y};
                        r_qx     <= i_query_x;
                        r_pos    <= '0;
                        r_hit    <= 1'b0;
                        priority if (i_action == ACT_ADD) begin
                            if (r_count >= CntW'(MAX_SEGMENTS)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_ADD;
                            end
                        end else if (i_action == ACT_QUERY) begin
                            r_state <= S_SCAN;
                        end else if (i_action == ACT_CLEAR) begin
                            r_count <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_ADD: begin
                    r_count <= r_count + CntW'(1);
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (w_valid && w_cover) begin
                        r_hit  <= 1'b1;
                        r_pick <= w_tail;
                    end
                    r_pos <= r_pos + IdxW'(1);
                    if (r_pos == IdxW'(MAX_SEGMENTS - 1)) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (!r_hit) begin
                        o_status <= ST_NO_MATCH;
                        r_state  <= S_DONE;
                    end else if (w_w == 17'sd0) begin
                        o_status <= ST_VERTICAL;
                        r_state  <= S_DONE;
                    end else begin
                        r_num    <= {w_mag[32:0], 8'd0};
                        r_den    <= w_w;
                        r_neg    <= w_prod[33];
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        o_found  <= 1'b1;
                        o_height <= {r_pick.ly, 8'd0} + w_q24;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
